>>> hw/rtl/gcd_pkg.sv
// shared constants and types for the great-circle distance pipeline
// no dependencies; used by every module under hw/rtl
package gcd_pkg;

   // fixed-point unity and pi
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [30:0] PI_Q29  = 31'd1686629713;
   localparam logic [60:0] ONE_Q60 = 61'h1000_0000_0000_0000;

   // degree-to-angle conversion: quotient by 45 after offsetting to a positive value
   localparam logic [7:0]  DIV_BASE   = 8'd45;
   localparam logic [43:0] DIV_OFFSET = 44'(45) << 37;
   localparam int          DIV_LAT    = 22;

   // cosine series, divisions by constants as multiply and shift
   localparam int HORNER_STEPS = 7;
   localparam int HORNER_SHIFT [HORNER_STEPS] = '{40, 40, 39, 38, 37, 36, 33};
   localparam logic [32:0] HORNER_MUL [HORNER_STEPS] = '{
      33'(((64'd1 << 40) + 64'd181) / 64'd182),
      33'(((64'd1 << 40) + 64'd131) / 64'd132),
      33'(((64'd1 << 39) + 64'd89)  / 64'd90),
      33'(((64'd1 << 38) + 64'd55)  / 64'd56),
      33'(((64'd1 << 37) + 64'd29)  / 64'd30),
      33'(((64'd1 << 36) + 64'd11)  / 64'd12),
      33'(((64'd1 << 33) + 64'd1)   / 64'd2)
   };
   localparam int COS_LAT = 2 + 2 * HORNER_STEPS;

   localparam int SQRT_LAT  = 31;
   localparam int ASIN_BITS = 30;
   localparam int CELL_LAT  = COS_LAT + 1;
   localparam int COMB_LAT  = 4;
   localparam int TOTAL_LAT = 1 + DIV_LAT + COS_LAT + COMB_LAT + SQRT_LAT
                              + ASIN_BITS * CELL_LAT + 1;

   // radius times 512 times pi, scaled for the final product
   localparam logic [32:0] DIST_K = 33'((64'd6371 * 64'd512 * 64'd1686629713) >> 20);

   // item travelling down the arcsine search
   typedef struct packed {
      logic        sat;
      logic [30:0] root;
      logic [29:0] ang;
      logic [29:0] probe;
   } asin_type;

endpackage

>>> hw/rtl/gcd_div45.sv
// pipelined division by 45, two quotient bits per stage
// depends on gcd_pkg
module gcd_div45 (
   input  logic        clock,
   input  logic        en,
   input  logic [43:0] num,
   output logic [31:0] quo
);
   localparam int Steps = gcd_pkg::DIV_LAT;

   logic [5:0]  rem_ff  [Steps-1];
   logic [43:0] work_ff [Steps];

   for (genvar i = 0; i < Steps; i++) begin : g_step
      logic [5:0]  rem_prev;
      logic [43:0] work_prev;
      logic [7:0]  x;
      logic [1:0]  d;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign work_prev = num;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign work_prev = work_ff[i-1];
      end

      always_comb begin
         x = {rem_prev, work_prev[43:42]};
         if (x >= 8'(3 * gcd_pkg::DIV_BASE)) begin
            d = 2'd3;
         end else if (x >= 8'(2 * gcd_pkg::DIV_BASE)) begin
            d = 2'd2;
         end else if (x >= gcd_pkg::DIV_BASE) begin
            d = 2'd1;
         end else begin
            d = 2'd0;
         end
      end

      // numerator shifts out at the top while quotient bits shift in below
      always_ff @(posedge clock) begin
         if (en) begin
            work_ff[i] <= {work_prev[41:0], d};
         end
      end

      if (i < Steps - 1) begin : g_rem
         logic [5:0] rem_in;
         assign rem_in = 6'(x - 8'(d) * gcd_pkg::DIV_BASE);
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= rem_in;
            end
         end
      end
   end

   assign quo = work_ff[Steps-1][31:0];

endmodule

>>> hw/rtl/gcd_cosq.sv
// pipelined cosine over the first quadrant, q30 result, series by horner steps
// depends on gcd_pkg
module gcd_cosq (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] m,
   output logic [30:0] cos_val
);
   localparam int Steps = gcd_pkg::HORNER_STEPS;

   logic [61:0] xp_in;
   logic [30:0] x_ff;
   logic [61:0] x2p_in;
   logic [31:0] x2_ff;
   logic [31:0] y_ff   [Steps];
   logic [30:0] t_ff   [Steps];
   logic [31:0] x2a_ff [Steps-1];
   logic [31:0] x2b_ff [Steps-1];

   assign xp_in  = 62'(m) * 62'(gcd_pkg::PI_Q29);
   assign x2p_in = 62'(x_ff) * 62'(x_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= xp_in[60:30];
         x2_ff <= x2p_in[61:30];
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      logic [30:0] t_prev;
      logic [31:0] x2_prev;
      logic [62:0] yp_in;
      logic [64:0] qp_in;
      logic [31:0] p_in;
      logic [30:0] t_in;

      if (i == 0) begin : g_first
         assign t_prev  = gcd_pkg::ONE_Q30;
         assign x2_prev = x2_ff;
      end else begin : g_next
         assign t_prev  = t_ff[i-1];
         assign x2_prev = x2b_ff[i-1];
      end

      assign yp_in = 63'(x2_prev) * 63'(t_prev);
      assign qp_in = 65'(y_ff[i]) * 65'(gcd_pkg::HORNER_MUL[i]);
      assign p_in  = 32'(qp_in >> gcd_pkg::HORNER_SHIFT[i]);
      // a term that goes below zero is held at zero
      assign t_in  = (p_in >= 32'(gcd_pkg::ONE_Q30)) ? '0
                   : 31'(32'(gcd_pkg::ONE_Q30) - p_in);

      always_ff @(posedge clock) begin
         if (en) begin
            y_ff[i] <= yp_in[61:30];
            t_ff[i] <= t_in;
         end
      end

      if (i < Steps - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               x2a_ff[i] <= x2_prev;
               x2b_ff[i] <= x2a_ff[i];
            end
         end
      end
   end

   assign cos_val = t_ff[Steps-1];

endmodule

>>> hw/rtl/gcd_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on gcd_pkg
module gcd_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [60:0] a,
   output logic [30:0] root
);
   localparam int Steps = gcd_pkg::SQRT_LAT;

   logic [60:0] rem_ff  [Steps-1];
   logic [30:0] root_ff [Steps];

   for (genvar i = 0; i < Steps; i++) begin : g_step
      localparam int B = Steps - 1 - i;
      logic [60:0] rem_prev;
      logic [30:0] root_prev;
      logic [62:0] inc;
      logic        take;

      if (i == 0) begin : g_first
         assign rem_prev  = a;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      // (root + 2^b)^2 - root^2
      assign inc  = (63'(root_prev) << (B + 1)) + (63'(1) << (2 * B));
      assign take = 63'(rem_prev) >= inc;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i] <= take ? (root_prev | (31'(1) << B)) : root_prev;
         end
      end

      if (i < Steps - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= take ? 61'(63'(rem_prev) - inc) : rem_prev;
            end
         end
      end
   end

   assign root = root_ff[Steps-1];

endmodule

>>> hw/rtl/gcd_asin_cell.sv
// one bit of the arcsine search: keeps the trial bit if its sine does not exceed root
// depends on gcd_pkg and gcd_cosq
module gcd_asin_cell (
   input  logic              clock,
   input  logic              en,
   input  gcd_pkg::asin_type cur,
   output gcd_pkg::asin_type nxt
);
   localparam int Depth = gcd_pkg::COS_LAT;

   logic [29:0]       cand;
   logic [30:0]       m_in;
   logic [30:0]       sin_val;
   logic [29:0]       cand_d;
   gcd_pkg::asin_type dly_ff [Depth];
   gcd_pkg::asin_type nxt_ff;

   // sine of the trial angle is the cosine of its complement
   assign cand = cur.ang | cur.probe;
   assign m_in = gcd_pkg::ONE_Q30 - 31'(cand);

   gcd_cosq u_sin (
      .clock   (clock),
      .en      (en),
      .m       (m_in),
      .cos_val (sin_val)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= cur;
         for (int i = 1; i < Depth; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign cand_d = dly_ff[Depth-1].ang | dly_ff[Depth-1].probe;

   always_ff @(posedge clock) begin
      if (en) begin
         nxt_ff.sat   <= dly_ff[Depth-1].sat;
         nxt_ff.root  <= dly_ff[Depth-1].root;
         nxt_ff.ang   <= (sin_val <= dly_ff[Depth-1].root) ? cand_d : dly_ff[Depth-1].ang;
         nxt_ff.probe <= dly_ff[Depth-1].probe >> 1;
      end
   end

   assign nxt = nxt_ff;

endmodule

>>> hw/rtl/great_circle_distance.sv
// haversine distance pipeline, one item per cycle sustained while the output is not
// backpressured. the depth is set mostly by the 30 arcsine cells,
// each a 16-stage cosine unit plus a compare stage, behind a 22-stage angle divider,
// a 16-stage trig stage, 4 combine stages and a 31-stage square root.
// reset clears the valid flags of the pipeline, the output register and the skid stage
module great_circle_distance (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata   // distance_km[22:0]
);
   localparam int Lat   = gcd_pkg::TOTAL_LAT;
   localparam int CosL  = gcd_pkg::COS_LAT;
   localparam int Cells = gcd_pkg::ASIN_BITS;

   function automatic logic [30:0] quarter_fold(input logic [31:0] ang);
      logic [30:0] r;
      r = {1'b0, ang[29:0]};
      return ang[30] ? 31'(gcd_pkg::ONE_Q30 - r) : r;
   endfunction

   logic        advance;
   logic        emit;
   logic        vld_ff [Lat];

   // input stage
   logic [27:0] lat_a, lat_b;
   logic [28:0] lon_a, lon_b;
   logic [28:0] dlat;
   logic [29:0] dlon;
   logic [43:0] n_lat_a_ff, n_lat_b_ff, n_dlat_ff, n_dlon_ff;

   assign lat_a = req_tdata[27:0];
   assign lon_a = req_tdata[56:28];
   assign lat_b = req_tdata[84:57];
   assign lon_b = req_tdata[113:85];
   assign dlat  = {lat_b[27], lat_b} - {lat_a[27], lat_a};
   assign dlon  = {lon_b[28], lon_b} - {lon_a[28], lon_a};

   always_ff @(posedge clock) begin
      if (advance) begin
         n_lat_a_ff <= {{7{lat_a[27]}}, lat_a, 9'b0} + gcd_pkg::DIV_OFFSET;
         n_lat_b_ff <= {{7{lat_b[27]}}, lat_b, 9'b0} + gcd_pkg::DIV_OFFSET;
         n_dlat_ff  <= {{7{dlat[28]}}, dlat, 8'b0} + gcd_pkg::DIV_OFFSET;
         n_dlon_ff  <= {{6{dlon[29]}}, dlon, 8'b0} + gcd_pkg::DIV_OFFSET;
      end
   end

   // degrees to binary angles
   logic [31:0] ang_lat_a, ang_lat_b, ang_dlat, ang_dlon;

   gcd_div45 u_div_lat_a (.clock(clock), .en(advance), .num(n_lat_a_ff), .quo(ang_lat_a));
   gcd_div45 u_div_lat_b (.clock(clock), .en(advance), .num(n_lat_b_ff), .quo(ang_lat_b));
   gcd_div45 u_div_dlat  (.clock(clock), .en(advance), .num(n_dlat_ff),  .quo(ang_dlat));
   gcd_div45 u_div_dlon  (.clock(clock), .en(advance), .num(n_dlon_ff),  .quo(ang_dlon));

   // trig: cosines of the latitudes, sines of the half differences
   logic [31:0] sang_dlat, sang_dlon;
   logic [30:0] c1, c2, s1, s2;
   logic [1:0]  negd_ff [CosL];

   assign sang_dlat = ang_dlat - 32'h4000_0000;
   assign sang_dlon = ang_dlon - 32'h4000_0000;

   gcd_cosq u_cos_a (.clock(clock), .en(advance), .m(quarter_fold(ang_lat_a)), .cos_val(c1));
   gcd_cosq u_cos_b (.clock(clock), .en(advance), .m(quarter_fold(ang_lat_b)), .cos_val(c2));
   gcd_cosq u_sin_1 (.clock(clock), .en(advance), .m(quarter_fold(sang_dlat)), .cos_val(s1));
   gcd_cosq u_sin_2 (.clock(clock), .en(advance), .m(quarter_fold(sang_dlon)), .cos_val(s2));

   // cosine is negative in the second and third quadrant
   always_ff @(posedge clock) begin
      if (advance) begin
         negd_ff[0] <= {ang_lat_b[31] ^ ang_lat_b[30], ang_lat_a[31] ^ ang_lat_a[30]};
         for (int i = 1; i < CosL; i++) begin
            negd_ff[i] <= negd_ff[i-1];
         end
      end
   end

   // combine into a
   logic [61:0] ccm_p, s1sq_p, u_p, term_p;
   logic [30:0] ccm_ff, u_ff;
   logic [60:0] s1sq_c0_ff, s1sq_c1_ff, s1sq_c2_ff, term_ff, a_ff;
   logic [30:0] s2_c0_ff, s2_c1_ff;
   logic        neg_c0_ff, neg_c1_ff, neg_c2_ff;
   logic        neg1, neg2;
   logic [61:0] sum_in;
   logic [60:0] a_in;

   assign neg1   = negd_ff[CosL-1][0] && (c1 != '0);
   assign neg2   = negd_ff[CosL-1][1] && (c2 != '0);
   assign ccm_p  = 62'(c1) * 62'(c2);
   assign s1sq_p = 62'(s1) * 62'(s1);
   assign u_p    = 62'(s2_c0_ff) * 62'(ccm_ff);
   assign term_p = 62'(u_ff) * 62'(s2_c1_ff);
   assign sum_in = 62'(s1sq_c2_ff) + 62'(term_ff);

   always_comb begin
      if (neg_c2_ff) begin
         a_in = (s1sq_c2_ff >= term_ff) ? s1sq_c2_ff - term_ff : '0;
      end else if (sum_in > 62'(gcd_pkg::ONE_Q60)) begin
         a_in = gcd_pkg::ONE_Q60;
      end else begin
         a_in = sum_in[60:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ccm_ff     <= ccm_p[60:30];
         s1sq_c0_ff <= s1sq_p[60:0];
         s2_c0_ff   <= s2;
         neg_c0_ff  <= neg1 != neg2;
         u_ff       <= u_p[60:30];
         s1sq_c1_ff <= s1sq_c0_ff;
         s2_c1_ff   <= s2_c0_ff;
         neg_c1_ff  <= neg_c0_ff;
         term_ff    <= term_p[60:0];
         s1sq_c2_ff <= s1sq_c1_ff;
         neg_c2_ff  <= neg_c1_ff;
         a_ff       <= a_in;
      end
   end

   // square root and arcsine search
   logic [30:0]       root;
   gcd_pkg::asin_type chain [Cells+1];

   gcd_isqrt u_sqrt (.clock(clock), .en(advance), .a(a_ff), .root(root));

   assign chain[0].sat   = root[30];
   assign chain[0].root  = root;
   assign chain[0].ang   = '0;
   assign chain[0].probe = {1'b1, 29'b0};

   for (genvar i = 0; i < Cells; i++) begin : g_cell
      gcd_asin_cell u_cell (
         .clock (clock),
         .en    (advance),
         .cur   (chain[i]),
         .nxt   (chain[i+1])
      );
   end

   // angle to distance
   logic [30:0] h;
   logic [63:0] dist_p;
   logic [22:0] dist_ff;

   assign h      = chain[Cells].sat ? gcd_pkg::ONE_Q30 : {1'b0, chain[Cells].ang};
   assign dist_p = 64'(h) * 64'(gcd_pkg::DIST_K);

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= dist_p[62:40];
      end
   end

   // valid flags follow the item down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lat; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < Lat; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // output register with a skid stage
   logic        rsp_vld_ff, skid_vld_ff;
   logic [22:0] rsp_data_ff, skid_data_ff;
   logic        out_take;

   assign advance    = !skid_vld_ff;
   assign req_tready = advance;
   assign emit       = advance && vld_ff[Lat-1];
   assign out_take   = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_vld_ff) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            rsp_vld_ff <= emit;
         end
      end else if (emit) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_data_ff <= skid_vld_ff ? skid_data_ff : dist_ff;
      end else if (emit) begin
         skid_data_ff <= dist_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

>>> tb/sv/great_circle_distance_tb.sv
// self-checking testbench for the great_circle_distance haversine pipeline
// depends on gcd_pkg (pipeline latency) and the great_circle_distance rtl
module great_circle_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LAT_MAX   = 94371840;
   localparam int LON_MAX   = 188743680;
   localparam int DRAIN_CYC = gcd_pkg::TOTAL_LAT + 40;
   localparam int CYC_LIMIT = 600000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;   // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;        // distance_km[22:0]

   logic [119:0] pend_q[$];
   logic [22:0]  dist_expected[$];
   int           idle_pct = 0;
   int           stall_pct = 0;
   bit           hold = 1'b0;
   int           errors = 0;
   int           n_sent = 0;
   int           n_checked = 0;
   int           cycles = 0;

   great_circle_distance dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- distance predictor ----------------
   function automatic logic [31:0] deg_to_angle(longint v, longint div);
      longint num;
      longint unsigned q;
      num = v * 4096 + div * (64'sd1 <<< 42);
      q = longint'(unsigned'(num)) / div;
      return q[31:0];
   endfunction

   function automatic longint cos_quarter(logic [31:0] m);
      longint unsigned x, x2, p;
      longint t;
      int divs[7] = '{182, 132, 90, 56, 30, 12, 2};
      x  = (64'(m) * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t  = 64'sd1 <<< 30;
      for (int i = 0; i < 7; i++) begin
         p = ((x2 * longint'(unsigned'(t))) >> 30) / divs[i];
         t = (64'sd1 <<< 30) - longint'(p);
         if (t < 0) t = 0;
      end
      return t;
   endfunction

   function automatic longint cos_angle(logic [31:0] a);
      logic [1:0]  q;
      logic [31:0] r, m;
      longint      v;
      q = a[31:30];
      r = {2'b00, a[29:0]};
      m = q[0] ? (32'h4000_0000 - r) : r;
      v = cos_quarter(m);
      return (q == 2'd1 || q == 2'd2) ? -v : v;
   endfunction

   function automatic longint sin_angle(logic [31:0] a);
      return cos_angle(a - 32'h4000_0000);
   endfunction

   function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [22:0] predict_distance(logic [119:0] d);
      longint lat_a, lon_a, lat_b, lon_b, c1, c2;
      longint unsigned s1, s2, ccm, term, a, r, h, cand, k, prod;
      bit neg;
      lat_a = longint'($signed(d[27:0]));
      lon_a = longint'($signed(d[56:28]));
      lat_b = longint'($signed(d[84:57]));
      lon_b = longint'($signed(d[113:85]));
      s1 = longint'(unsigned'(sin_angle(deg_to_angle(lat_b - lat_a, 720))));
      s2 = longint'(unsigned'(sin_angle(deg_to_angle(lon_b - lon_a, 720))));
      // sine may be negative after the half-angle fold
      if (longint'(s1) < 0) s1 = -s1;
      if (longint'(s2) < 0) s2 = -s2;
      c1 = cos_angle(deg_to_angle(lat_a, 360));
      c2 = cos_angle(deg_to_angle(lat_b, 360));
      neg = (c1 < 0) != (c2 < 0);
      if (c1 < 0) c1 = -c1;
      if (c2 < 0) c2 = -c2;
      ccm  = (longint'(unsigned'(c1)) * longint'(unsigned'(c2))) >> 30;
      term = ((s2 * ccm) >> 30) * s2;
      a = s1 * s1;
      if (neg) a = (a >= term) ? a - term : 0;
      else     a = a + term;
      if (a > (64'd1 << 60)) a = 64'd1 << 60;
      r = isqrt(a);
      if (r >= (64'd1 << 30)) begin
         h = 64'd1 << 30;
      end else begin
         h = 0;
         for (int b = 29; b >= 0; b--) begin
            cand = h | (64'd1 << b);
            if (longint'(unsigned'(sin_angle(cand[31:0]))) <= longint'(r)) h = cand;
         end
      end
      k = (64'd6371 * 64'd512 * 64'd1686629713) >> 20;
      prod = (h * k) >> 40;
      return prod[22:0];
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic logic [119:0] pack_points(int la, int oa, int lb, int ob);
      logic [119:0] d;
      d = '0;
      d[27:0]   = la[27:0];
      d[56:28]  = oa[28:0];
      d[84:57]  = lb[27:0];
      d[113:85] = ob[28:0];
      return d;
   endfunction

   function automatic void add_item(logic [119:0] d);
      pend_q.insert(pend_q.size(), d);
   endfunction

   function automatic int rand_lat();
      return int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
   endfunction

   function automatic int rand_lon();
      return int'($urandom_range(2 * LON_MAX)) - LON_MAX;
   endfunction

   function automatic logic [119:0] rand_points();
      int sel, la, oa;
      sel = $urandom_range(99);
      la = rand_lat();
      oa = rand_lon();
      if (sel < 80) return pack_points(la, oa, rand_lat(), rand_lon());
      // any bit pattern, out-of-range coordinates wrap
      if (sel < 92) return pack_points($urandom(), $urandom(), $urandom(), $urandom());
      // near-antipodal pair
      if (sel < 96)
         return pack_points(la, oa, -la + int'($urandom_range(64)) - 32,
                            oa + (oa < 0 ? LON_MAX : -LON_MAX) + int'($urandom_range(64)) - 32);
      // nearly the same point
      return pack_points(la, oa, la + int'($urandom_range(2000)) - 1000,
                         oa + int'($urandom_range(2000)) - 1000);
   endfunction

   task automatic wait_sent();
      while (pend_q.size() != 0 || req_tvalid) @(negedge clock);
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            dist_expected.insert(dist_expected.size(), predict_distance(req_tdata));
            n_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (!hold && pend_q.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pend_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= int'($urandom_range(99)) >= stall_pct;
         if (rsp_tvalid && rsp_tready) begin
            if (dist_expected.size() == 0) begin
               $error("distance_km: no item expected, actual %0d", rsp_tdata[22:0]);
               errors++;
            end else begin
               logic [22:0] want;
               want = dist_expected.pop_front();
               if (rsp_tdata[22:0] !== want) begin
                  $error("distance_km mismatch: expected %0d actual %0d", want, rsp_tdata[22:0]);
                  errors++;
               end
               n_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------- phases ----------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, equator, poles, antipodes, out-of-range wrap
      add_item(pack_points(0, 0, 0, 0));
      add_item(pack_points(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX));
      add_item(pack_points(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
      add_item(pack_points(LAT_MAX, 0, -LAT_MAX, 0));
      add_item(pack_points(0, 0, 0, LON_MAX));
      add_item(pack_points(0, -LON_MAX, 0, LON_MAX));
      add_item(pack_points(0, 0, 0, -LON_MAX));
      add_item(pack_points(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
      add_item(pack_points(1, 0, 0, 0));
      add_item(pack_points(0, 0, 0, 1));
      add_item(pack_points(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 2,
                           LON_MAX / 3 - LON_MAX));
      add_item(pack_points(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1));
      add_item(pack_points((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28)));
      // latitudes past the pole: cosines of opposite sign, the difference for a can go below zero
      add_item(pack_points(LAT_MAX + 20000000, 0, LAT_MAX - 20000000, 0));
      add_item(pack_points(120000000, 5000, 60000000, LON_MAX));
      add_item(pack_points(-120000000, LON_MAX, 80000000, -LON_MAX));
      add_item(pack_points(LAT_MAX, 0, LAT_MAX, LON_MAX));
      add_item(pack_points(-1, -1, -1, -1));
      add_item(pack_points(1000, 2000, -1000, -2000));
      for (int i = 0; i < 200; i++) add_item(rand_points());
      wait_sent();

      idle_pct = 57; stall_pct = 0;
      for (int i = 0; i < 230; i++) add_item(rand_points());
      wait_sent();

      // sender holds off until the pipeline has fully drained
      hold = 1'b1;
      while (dist_expected.size() != 0) @(negedge clock);
      hold = 1'b0;

      idle_pct = 0; stall_pct = 57;
      for (int i = 0; i < 230; i++) add_item(rand_points());
      wait_sent();

      idle_pct = 24; stall_pct = 24;
      for (int i = 0; i < 120; i++) add_item(rand_points());
      wait_sent();
      idle_pct = 0; stall_pct = 0;
      for (int i = 0; i < 100; i++) add_item(rand_points());
      wait_sent();

      while (dist_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);

      $display("covered %0d coordinate pairs, %0d distances checked, over four idle/stall mixes",
               n_sent, n_checked);
      if (errors == 0 && dist_expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> great_circle_distance.f
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_div45.sv
hw/rtl/gcd_cosq.sv
hw/rtl/gcd_isqrt.sv
hw/rtl/gcd_asin_cell.sv
hw/rtl/great_circle_distance.sv
tb/sv/great_circle_distance_tb.sv
